// ----- rtl/tsd_pkg.sv -----
`default_nettype none
// ============================================================================
// tsd_pkg
// Shared sizes, constants, types and the accumulate function of the
// whole-degree sine unit (truncated Taylor series in fixed point).
// ============================================================================
package tsd_pkg;

  // Fixed-point format and series length.
  localparam int FRAC_BITS = 24;
  localparam int MAX_TERMS = 16;

  // Port field widths.
  localparam int ANG_W  = 10;
  localparam int CFG_W  = 5;
  localparam int SINE_W = 32;

  // Degrees to radians: x = |angle| * PI_NUM / (HALF_TURN_DEG * PI_DEN).
  localparam longint unsigned PI_NUM        = 64'd31416;
  localparam longint unsigned PI_DEN        = 64'd10000;
  localparam longint unsigned HALF_TURN_DEG = 64'd180;
  localparam longint unsigned XD = HALF_TURN_DEG * PI_DEN;
  localparam longint unsigned XK = PI_NUM << FRAC_BITS;

  // The scale factor XK / XD is split into a whole part and a remainder,
  // so only the remainder product needs a division by XD.
  localparam longint unsigned XQ = XK / XD;
  localparam longint unsigned XR = XK % XD;
  localparam int XQ_W = $clog2(XQ + 64'd1);
  localparam int XD_W = $clog2(XD + 64'd1);

  // Remainder numerator stays below (2^(ANG_W-1) + 1) * XD.
  localparam int Y_W = $clog2(((64'd1 << (ANG_W - 1)) + 64'd1) * XD);
  localparam longint unsigned RX = (64'd1 << Y_W) / XD;
  localparam int RX_W = $clog2(RX + 64'd1);

  // Internal widths. The angle magnitude is at most 512 degrees, so
  // |x| < 9, x^2 < 80, every term is below 1024, one term times x^2 is
  // below 2^17, and the sum of all term magnitudes is below 2^13.
  localparam int XM_W  = FRAC_BITS + 4;
  localparam int X2_W  = FRAC_BITS + 7;
  localparam int M_W   = FRAC_BITS + 10;
  localparam int N_W   = FRAC_BITS + 18;
  localparam int ACC_W = FRAC_BITS + 16;
  localparam int P_W   = M_W + X2_W;

  // Division of a term by (2k-2)(2k-1) through a reciprocal of 2^N_W / d.
  // The smallest divisor is 6, so the reciprocal fits in N_W - 2 bits.
  localparam int NL     = N_W / 2;
  localparam int NH     = N_W - NL;
  localparam int R_W    = N_W - 2;
  localparam int FULL_W = N_W + R_W;
  localparam int D_W    = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);
  localparam int IDX_W  = $clog2(MAX_TERMS + 1);

  // Sized constants for the radian conversion.
  localparam logic [XQ_W-1:0] XQ_C    = XQ_W'(XQ);
  localparam logic [XD_W-1:0] XR_C    = XD_W'(XR);
  localparam logic [XD_W-1:0] XD_C    = XD_W'(XD);
  localparam logic [Y_W-1:0]  XD_HALF = Y_W'(XD / 64'd2);
  localparam logic [RX_W-1:0] RX_C    = RX_W'(RX);

  // Per-item data that rides along the term pipeline.
  typedef struct packed {
    logic                    neg;
    logic [CFG_W-1:0]        nterms;
    logic signed [ACC_W-1:0] acc;
    logic [X2_W-1:0]         x2;
  } tsd_meta_t;

  // Meta data plus the magnitude of the latest term.
  typedef struct packed {
    tsd_meta_t       meta;
    logic [M_W-1:0]  m;
  } tsd_item_t;

  // Adds term number idx with magnitude m, if idx is within the term count.
  // Odd terms carry the sign of the angle and even terms the opposite sign.
  function automatic logic signed [ACC_W-1:0] tsd_acc_add(
    input logic signed [ACC_W-1:0] acc,
    input logic [M_W-1:0]          m,
    input logic                    neg,
    input logic [IDX_W-1:0]        idx,
    input logic [CFG_W-1:0]        nterms
  );
    logic signed [ACC_W-1:0] term;
    logic                    tneg;
    term = signed'(ACC_W'(m));
    tneg = neg ^ ~idx[0];
    if (int'(idx) > int'(nterms)) begin
      return acc;
    end
    return tneg ? (acc - term) : (acc + term);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tsd_ifs.sv -----
`default_nettype none
// ============================================================================
// tsd_ifs
// Valid/ready channels of the sine unit: angle in, sine value out.
// ============================================================================

// Angle channel.
interface tsd_in_if;
  import tsd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_degrees;
  modport source (output valid, output angle_degrees, input ready);
  modport sink   (input valid, input angle_degrees, output ready);
endinterface

// Sine result channel.
interface tsd_out_if;
  import tsd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SINE_W-1:0] sine_value;
  modport source (output valid, output sine_value, input ready);
  modport sink   (input valid, input sine_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/tsd_front.sv -----
`default_nettype none
// ============================================================================
// tsd_front
// Five-stage front end: angle magnitude to radians (rounded), then x^2.
// Emits the first term (x itself) with a cleared accumulator.
// ============================================================================
module tsd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            valid_i,
  input  logic signed [tsd_pkg::ANG_W-1:0] angle_i,
  input  logic [tsd_pkg::CFG_W-1:0]       nterms_i,
  output logic                            valid_o,
  output tsd_pkg::tsd_item_t              item_o
);
  import tsd_pkg::*;

  // Stage A: magnitude times the whole part and the remainder of the scale.
  logic                  v_a_r;
  logic                  neg_a_r;
  logic [CFG_W-1:0]      nt_a_r;
  logic [XM_W-1:0]       base_a_r;
  logic [Y_W-1:0]        y_a_r;
  logic [ANG_W-1:0]      mag;
  logic [XM_W-1:0]       base_a_nxt;
  logic [Y_W-1:0]        y_a_nxt;

  // Stage B: estimated quotient of the remainder product.
  logic                  v_b_r;
  logic                  neg_b_r;
  logic [CFG_W-1:0]      nt_b_r;
  logic [XM_W-1:0]       base_b_r;
  logic [Y_W-1:0]        y_b_r;
  logic [RX_W-1:0]       qe_b_r;
  logic [Y_W+RX_W-1:0]   yr_prod;

  // Stage C: corrected radian value.
  logic                  v_c_r;
  logic                  neg_c_r;
  logic [CFG_W-1:0]      nt_c_r;
  logic [XM_W-1:0]       xm_c_r;
  logic [RX_W+XD_W-1:0]  qx_prod;
  logic [Y_W-1:0]        rem_c;
  logic [XM_W-1:0]       xm_c_nxt;

  // Stage D: raw square.
  logic                  v_d_r;
  logic                  neg_d_r;
  logic [CFG_W-1:0]      nt_d_r;
  logic [XM_W-1:0]       xm_d_r;
  logic [2*XM_W-1:0]     sq_d_r;

  // Stage E: rounded square, output item.
  logic                  v_e_r;
  tsd_item_t             item_e_r;
  logic [2*XM_W-1:0]     sq_rnd;
  tsd_item_t             item_e_nxt;

  // Magnitude and the two scale products.
  always_comb begin
    mag        = angle_i[ANG_W-1] ? (~angle_i + ANG_W'(1)) : angle_i;
    base_a_nxt = XM_W'(mag) * XM_W'(XQ_C);
    y_a_nxt    = Y_W'(mag) * Y_W'(XR_C) + XD_HALF;
  end

  // Reciprocal estimate; it is at most one below the true quotient.
  assign yr_prod = (Y_W + RX_W)'(y_a_r) * (Y_W + RX_W)'(RX_C);

  // Correction of the estimate and the final rounded radian value.
  always_comb begin
    qx_prod  = (RX_W + XD_W)'(qe_b_r) * (RX_W + XD_W)'(XD_C);
    rem_c    = y_b_r - qx_prod[Y_W-1:0];
    xm_c_nxt = base_b_r + XM_W'(qe_b_r) + XM_W'(rem_c >= Y_W'(XD_C));
  end

  // Rounding of the square to the fraction width.
  always_comb begin
    sq_rnd               = sq_d_r + ((2*XM_W)'(1) << (FRAC_BITS - 1));
    item_e_nxt.meta.neg    = neg_d_r;
    item_e_nxt.meta.nterms = nt_d_r;
    item_e_nxt.meta.acc    = '0;
    item_e_nxt.meta.x2     = sq_rnd[FRAC_BITS+X2_W-1:FRAC_BITS];
    item_e_nxt.m           = M_W'(xm_d_r);
  end

  // Valid bits move only when the whole pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else if (adv) begin
      v_a_r <= valid_i;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      neg_a_r  <= angle_i[ANG_W-1];
      nt_a_r   <= nterms_i;
      base_a_r <= base_a_nxt;
      y_a_r    <= y_a_nxt;

      neg_b_r  <= neg_a_r;
      nt_b_r   <= nt_a_r;
      base_b_r <= base_a_r;
      y_b_r    <= y_a_r;
      qe_b_r   <= yr_prod[Y_W+RX_W-1:Y_W];

      neg_c_r  <= neg_b_r;
      nt_c_r   <= nt_b_r;
      xm_c_r   <= xm_c_nxt;

      neg_d_r  <= neg_c_r;
      nt_d_r   <= nt_c_r;
      xm_d_r   <= xm_c_r;
      sq_d_r   <= (2*XM_W)'(xm_c_r) * (2*XM_W)'(xm_c_r);

      item_e_r <= item_e_nxt;
    end
  end

  assign valid_o = v_e_r;
  assign item_o  = item_e_r;

endmodule
`default_nettype wire

// ----- rtl/tsd_term.sv -----
`default_nettype none
// ============================================================================
// tsd_term
// Five-stage slice for one series term: adds the previous term to the
// accumulator, multiplies it by x^2 and divides by (2k-2)(2k-1) with rounding.
// ============================================================================
module tsd_term (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [tsd_pkg::IDX_W-1:0]   prev_idx,
  input  logic [tsd_pkg::D_W-1:0]     term_div,
  input  logic [tsd_pkg::R_W-1:0]     term_rcp,
  input  logic                        valid_i,
  input  tsd_pkg::tsd_item_t          item_i,
  output logic                        valid_o,
  output tsd_pkg::tsd_item_t          item_o
);
  import tsd_pkg::*;

  // Stage 1: accumulate the previous term, product with x^2.
  logic                 v1_r;
  tsd_meta_t            meta1_r;
  logic [P_W-1:0]       prod1_r;
  tsd_meta_t            meta1_nxt;

  // Stage 2: rounded product plus half the divisor.
  logic                 v2_r;
  tsd_meta_t            meta2_r;
  logic [N_W-1:0]       n2_r;
  logic [N_W-1:0]       n2_nxt;

  // Stage 3: partial products with the reciprocal.
  logic                 v3_r;
  tsd_meta_t            meta3_r;
  logic [N_W-1:0]       n3_r;
  logic [NH+R_W-1:0]    pph3_r;
  logic [NL+R_W-1:0]    ppl3_r;

  // Stage 4: quotient estimate.
  logic                 v4_r;
  tsd_meta_t            meta4_r;
  logic [N_W-1:0]       n4_r;
  logic [R_W-1:0]       qe4_r;
  logic [FULL_W-1:0]    full4;

  // Stage 5: corrected quotient, the new term.
  logic                 v5_r;
  tsd_item_t            item5_r;
  logic [R_W+D_W-1:0]   qd5;
  logic [N_W-1:0]       rem5;
  logic [R_W-1:0]       q5;
  tsd_item_t            item5_nxt;

  always_comb begin
    meta1_nxt     = item_i.meta;
    meta1_nxt.acc = tsd_acc_add(item_i.meta.acc, item_i.m, item_i.meta.neg,
                                prev_idx, item_i.meta.nterms);
  end

  // Round the product back to the fraction width and add half the divisor.
  assign n2_nxt = N_W'(prod1_r[P_W-1:FRAC_BITS]) + N_W'(prod1_r[FRAC_BITS-1])
                + N_W'(term_div[D_W-1:1]);

  // The estimate floor(n * rcp / 2^N_W) is the quotient or one below it.
  assign full4 = (FULL_W'(pph3_r) << NL) + FULL_W'(ppl3_r);

  always_comb begin
    qd5            = (R_W + D_W)'(qe4_r) * (R_W + D_W)'(term_div);
    rem5           = n4_r - qd5[N_W-1:0];
    q5             = qe4_r + R_W'(rem5 >= N_W'(term_div));
    item5_nxt.meta = meta4_r;
    item5_nxt.m    = q5[M_W-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta1_r <= meta1_nxt;
      prod1_r <= P_W'(item_i.m) * P_W'(item_i.meta.x2);

      meta2_r <= meta1_r;
      n2_r    <= n2_nxt;

      meta3_r <= meta2_r;
      n3_r    <= n2_r;
      pph3_r  <= (NH + R_W)'(n2_r[N_W-1:NL]) * (NH + R_W)'(term_rcp);
      ppl3_r  <= (NL + R_W)'(n2_r[NL-1:0]) * (NL + R_W)'(term_rcp);

      meta4_r <= meta3_r;
      n4_r    <= n3_r;
      qe4_r   <= full4[FULL_W-1:N_W];

      item5_r <= item5_nxt;
    end
  end

  assign valid_o = v5_r;
  assign item_o  = item5_r;

endmodule
`default_nettype wire

// ----- rtl/taylor_sine_degrees_unit.sv -----
`default_nettype none
// ============================================================================
// taylor_sine_degrees_unit
// Sine of a whole-degree angle by a truncated Taylor series, 24 fraction bits.
// ============================================================================
//
//   Channel  Direction  Payload                         Transaction when
//   in_ch    sink       angle_degrees  signed 10 bits   valid && ready
//   out_ch   source     sine_value     signed 32 bits   valid && ready
//   cfg_*    write      term_count     5 bits           cfg_wr_en high
//
// One angle enters per cycle unless the pipeline stalls; the path is
// one input stage, a five-stage radian front end, five stages for each term
// after the first, and the output register.
// The whole pipeline advances together; it stalls only while a result waits
// in the output register, so a stall drops and repeats nothing.
// Reset clears the valid bits and sets term_count to 1.
// The term count is taken with each angle when it is accepted.
//
module taylor_sine_degrees_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  tsd_in_if.sink                      in_ch,
  tsd_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [tsd_pkg::CFG_W-1:0]   cfg_wr_data
);
  import tsd_pkg::*;

  logic                     adv;
  logic [CFG_W-1:0]         cfg_term_count_r;
  logic [CFG_W-1:0]         nterms_clamp;

  // Input stage.
  logic                     in_vld_r;
  logic signed [ANG_W-1:0]  in_angle_r;
  logic [CFG_W-1:0]         in_nterms_r;

  // Term pipeline links; entry 0 holds the first term.
  logic                     link_vld  [MAX_TERMS];
  tsd_item_t                link_item [MAX_TERMS];

  // Output stage.
  logic signed [ACC_W-1:0]  acc_final;
  logic signed [SINE_W-1:0] sine_sat;
  logic                     out_vld_r;
  logic signed [SINE_W-1:0] out_sine_r;

  // Everything moves unless a finished result is still waiting.
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Term count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_term_count_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      cfg_term_count_r <= cfg_wr_data;
    end
  end

  // A term count above the series length sums the whole series.
  assign nterms_clamp = (int'(cfg_term_count_r) > MAX_TERMS) ? CFG_W'(MAX_TERMS)
                                                              : cfg_term_count_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_angle_r  <= in_ch.angle_degrees;
      in_nterms_r <= nterms_clamp;
    end
  end

  // Radians and x^2.
  tsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (in_vld_r),
    .angle_i  (in_angle_r),
    .nterms_i (in_nterms_r),
    .valid_o  (link_vld[0]),
    .item_o   (link_item[0])
  );

  // One slice per term from the second on.
  for (genvar k = 2; k <= MAX_TERMS; k++) begin : g_term
    localparam longint unsigned DIV_K = longint'((2 * k - 2) * (2 * k - 1));
    localparam longint unsigned RCP_K = (64'd1 << N_W) / DIV_K;

    tsd_term u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .prev_idx (IDX_W'(k - 1)),
      .term_div (D_W'(DIV_K)),
      .term_rcp (R_W'(RCP_K)),
      .valid_i  (link_vld[k-2]),
      .item_i   (link_item[k-2]),
      .valid_o  (link_vld[k-1]),
      .item_o   (link_item[k-1])
    );
  end

  // Last term and saturation to the output range.
  always_comb begin
    acc_final = tsd_acc_add(link_item[MAX_TERMS-1].meta.acc,
                            link_item[MAX_TERMS-1].m,
                            link_item[MAX_TERMS-1].meta.neg,
                            IDX_W'(MAX_TERMS),
                            link_item[MAX_TERMS-1].meta.nterms);
    if (acc_final > ACC_W'(signed'({1'b0, {(SINE_W-1){1'b1}}}))) begin
      sine_sat = {1'b0, {(SINE_W-1){1'b1}}};
    end else if (acc_final < ACC_W'(signed'({1'b1, {(SINE_W-1){1'b0}}}))) begin
      sine_sat = {1'b1, {(SINE_W-1){1'b0}}};
    end else begin
      sine_sat = acc_final[SINE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= link_vld[MAX_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sine_r <= sine_sat;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.sine_value = out_sine_r;

endmodule
`default_nettype wire

// ----- dv/tb_taylor_sine_degrees_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_taylor_sine_degrees_unit
// Self-checking bench for the whole-degree sine unit. A clocked driver sends
// angles from a pending queue. At each accepted transaction it predicts the
// truncated Taylor sum with 24 fraction bits. A clocked monitor compares each
// result with the oldest prediction. Both sides insert random wait cycles.
// One phase holds the result side off long enough to back up the pipeline.
// ============================================================================
module tb_taylor_sine_degrees_unit;
  import tsd_pkg::*;

  // Wait policies for the two sides of the block.
  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;

  localparam longint unsigned RAD_NUM  = 64'd31416;
  localparam longint unsigned RAD_DEN  = 64'd1800000;
  localparam longint unsigned TERM_CAP = 64'd1 << 61;
  localparam longint          SUM_CAP  = 64'sd1 << 62;
  localparam int PIPE_CYCLES  = 5 * MAX_TERMS + 2;
  localparam int LONG_HOLD    = 300;
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;

  logic clk;
  logic rst_n;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  tsd_in_if  in_if ();
  tsd_out_if out_if ();

  taylor_sine_degrees_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic signed [ANG_W-1:0]  angle_queue[$];
  logic signed [SINE_W-1:0] sine_expect[$];
  logic [CFG_W-1:0]         term_count_shadow;
  idle_mode_e               send_mode;
  idle_mode_e               recv_mode;
  int                       send_wait;
  int                       recv_wait;
  int                       hold_req;
  int                       hold_seen;
  int                       errors;

  // Rounded fixed-point product a * b / 2^FRAC_BITS, capped like a term.
  function automatic longint unsigned frac_mul(input longint unsigned a,
                                               input longint unsigned b);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b} + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (prod > {64'd0, TERM_CAP}) begin
      return TERM_CAP;
    end
    return prod[63:0];
  endfunction

  // Expected sine value of one angle for a given term count.
  function automatic logic signed [SINE_W-1:0] taylor_sine(
    input logic signed [ANG_W-1:0] angle,
    input logic [CFG_W-1:0]        nterms
  );
    longint unsigned mag, xmag, xsq, term, div;
    longint          sum;
    int              n;
    logic            neg, tneg;
    neg = angle[ANG_W-1];
    mag = 64'(unsigned'(angle));
    if (neg) begin
      mag = (64'd1 << ANG_W) - mag;
    end
    xmag = (((mag * RAD_NUM) << FRAC_BITS) + RAD_DEN / 2) / RAD_DEN;
    xsq  = frac_mul(xmag, xmag);
    term = xmag;
    n    = (int'(nterms) > MAX_TERMS) ? MAX_TERMS : int'(nterms);
    sum  = 0;
    for (int k = 1; k <= n; k++) begin
      if (k >= 2) begin
        div  = longint'((2 * k - 2) * (2 * k - 1));
        term = (frac_mul(term, xsq) + div / 2) / div;
      end
      // Odd terms carry the angle's sign, even terms the opposite one.
      tneg = neg ^ (k % 2 == 0);
      sum  = tneg ? sum - longint'(term) : sum + longint'(term);
      if (sum > SUM_CAP) sum = SUM_CAP;
      if (sum < -SUM_CAP) sum = -SUM_CAP;
    end
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return SINE_W'(sum);
  endfunction

  function automatic int draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 12)) : 0;
      default:     return int'($urandom_range(0, 12));
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Angle driver: predicts each accepted transaction, then offers the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.angle_degrees <= '0;
      send_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        sine_expect.push_back(taylor_sine(in_if.angle_degrees, term_count_shadow));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (angle_queue.size() != 0) begin
          in_if.valid         <= 1'b1;
          in_if.angle_degrees <= angle_queue.pop_front();
          send_wait = draw_wait(send_mode);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction and paces ready.
  always @(posedge clk) begin
    logic signed [SINE_W-1:0] want;
    logic                     fire;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      fire = out_if.valid && out_if.ready;
      if (fire) begin
        if (sine_expect.size() == 0) begin
          $display("%0t: unexpected sine value %0d", $time, out_if.sine_value);
          errors++;
        end else begin
          want = sine_expect.pop_front();
          if (out_if.sine_value !== want) begin
            $display("%0t: sine_value mismatch, expected %0d, actual %0d",
                     $time, want, out_if.sine_value);
            errors++;
          end
        end
      end
      // A hold request starts a long stall counted here.
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        recv_wait = LONG_HOLD;
      end else if (fire) begin
        recv_wait = draw_wait(recv_mode);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Waits until the block holds no work and nothing is pending.
  task automatic wait_drained();
    @(negedge clk);
    while (angle_queue.size() != 0 || in_if.valid || sine_expect.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes term_count; only called while the block is idle.
  task automatic write_term_count(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    term_count_shadow = value;
  endtask

  // Random angles, mostly within a full turn, some over the whole field.
  task automatic queue_angles(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        angle_queue.push_back(ANG_W'($urandom()));
      end else begin
        angle_queue.push_back(ANG_W'($urandom_range(0, 720) - 360));
      end
    end
  endtask

  task automatic queue_list(input int list[]);
    foreach (list[i]) begin
      angle_queue.push_back(ANG_W'(list[i]));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [CFG_W-1:0] tc;
    in_if.valid         = 1'b0;
    in_if.angle_degrees = '0;
    out_if.ready        = 1'b0;
    term_count_shadow   = CFG_W'(1);
    send_mode           = IDLE_FULL;
    recv_mode           = IDLE_FULL;
    hold_req            = 0;
    hold_seen           = 0;
    errors              = 0;
    rst_n               = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset term count of one: the sum is just x.
    queue_list('{0, 1, -1, 90, -90, 180});
    wait_drained();
    // No terms at all gives zero.
    write_term_count('0);
    recv_mode = IDLE_SPARSE;
    queue_list('{360, -360, 45});
    wait_drained();
    // Full series over the extremes, out-of-range angles included.
    write_term_count(CFG_W'(MAX_TERMS));
    send_mode = IDLE_SPARSE;
    queue_list('{360, -360, 511, -512, 270, -270, 30, -30, 359, 256});
    wait_drained();
    // Counts beyond the maximum behave as the maximum.
    write_term_count(CFG_ALL_ONES);
    queue_list('{511, -512});
    wait_drained();
    write_term_count(CFG_W'(MAX_TERMS + 1));
    queue_list('{-180, 90});
    wait_drained();

    // Random phases with varying counts and pacing.
    for (int phase = 0; phase < 11; phase++) begin
      case ($urandom_range(0, 5))
        0:       tc = CFG_W'(1);
        1:       tc = CFG_W'(MAX_TERMS);
        2:       tc = CFG_W'($urandom_range(0, 31));
        default: tc = CFG_W'($urandom_range(1, MAX_TERMS));
      endcase
      write_term_count(tc);
      send_mode = idle_mode_e'($urandom_range(0, 2));
      recv_mode = idle_mode_e'($urandom_range(0, 2));
      if (phase == 5) begin
        // Long result stall while angles keep coming back to back.
        send_mode = IDLE_NONE;
        hold_req++;
        queue_angles(180);
      end else begin
        queue_angles(95);
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (PIPE_CYCLES + 20) @(posedge clk);
    if (sine_expect.size() != 0) begin
      $display("%0t: %0d sine values never arrived", $time, sine_expect.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_taylor_sine_degrees_unit: clean");
    end else begin
      $display("tb_taylor_sine_degrees_unit: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb_taylor_sine_degrees_unit: errors");
    $finish;
  end

endmodule
